@@ src/csrp_pkg.sv @@
package csrp_pkg;

    // Fixed field widths
    localparam int CFG_W       = 11;
    localparam int SLOT_W      = 10;
    localparam int GROUP_OUT_W = 10;
    localparam int COUNT_OUT_W = 11;

    // Depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // Configuration register indexes
    localparam logic REG_GROUP_COUNT   = 1'b0;
    localparam logic REG_CACHED_GROUPS = 1'b1;

    // Result kinds
    localparam logic KIND_COPY = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Commands passed from front to back
    typedef enum logic [1:0] {
        OP_PAIR,
        OP_END,
        OP_INIT
    } csrp_op_t;

    typedef struct packed {
        csrp_op_t op;
        logic     last;
        logic     unmatched;
    } csrp_cmd_t;

    // Which kind of group the pending queue holds
    typedef enum logic {
        SIDE_LOAD,
        SIDE_EVICT
    } csrp_side_t;

    // One entry of the group-to-slot map
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } csrp_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_HEAD,
        F_END
    } csrp_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SWEEP,
        B_CLEAR,
        B_WRITE
    } csrp_back_state_t;

endpackage

@@ src/csrp_front.sv @@
module csrp_front
    import csrp_pkg::*;
#(
    parameter int MAX_GROUPS = 1024,
    parameter int GW         = 10,
    parameter int CW         = 11
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            action,
    input  logic            needs_load,
    input  logic            may_evict,
    input  logic            final_group,
    input  logic [CW-1:0]   count,
    output logic            front_busy,
    output logic            push,
    output csrp_cmd_t       push_cmd,
    output logic [GW-1:0]   push_load,
    output logic [GW-1:0]   push_evict
);

    csrp_front_state_t state_reg, state_next;
    csrp_side_t        side_reg, side_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [CW-1:0]     head_reg, head_next;
    logic [CW-1:0]     tail_reg, tail_next;
    logic              act_reg, nl_reg, me_reg, fin_reg;

    // Pending groups of the side that is ahead
    logic [GW-1:0]     fifo_mem [MAX_GROUPS];
    logic [GW-1:0]     fifo_rd_reg;
    logic              fifo_we, fifo_re;

    logic              in_range, nl, me, empty, need_head;
    logic [GW-1:0]     g;

    assign in_range   = scan_reg < count;
    assign nl         = nl_reg & in_range;
    assign me         = me_reg & in_range;
    assign g          = scan_reg[GW-1:0];
    assign empty      = head_reg == tail_reg;
    assign need_head  = !empty && ((side_reg == SIDE_LOAD && me) ||
                                   (side_reg == SIDE_EVICT && nl));
    assign front_busy = state_reg != F_IDLE;

    // State and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            side_reg  <= SIDE_LOAD;
            scan_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            scan_reg  <= scan_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    // Latch the item flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            nl_reg  <= needs_load;
            me_reg  <= may_evict;
            fin_reg <= final_group;
        end
    end

    // Pending queue storage
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg[GW-1:0]] <= g;
        end
        if (fifo_re)
        begin
            fifo_rd_reg <= fifo_mem[head_reg[GW-1:0]];
        end
    end

    // Classify the item and issue commands
    always_comb
    begin
        state_next         = state_reg;
        side_next          = side_reg;
        scan_next          = scan_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        fifo_we            = 1'b0;
        fifo_re            = 1'b0;
        push               = 1'b0;
        push_cmd.op        = OP_PAIR;
        push_cmd.last      = !fin_reg;
        push_cmd.unmatched = 1'b0;
        push_load          = g;
        push_evict         = g;

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_CLASS;
                end
            end

            F_CLASS:
            begin
                if (act_reg)
                begin
                    push        = 1'b1;
                    push_cmd.op = OP_INIT;
                    scan_next   = '0;
                    head_next   = '0;
                    tail_next   = '0;
                    state_next  = F_IDLE;
                end
                else if (need_head)
                begin
                    fifo_re    = 1'b1;
                    state_next = F_HEAD;
                end
                else
                begin
                    if (in_range)
                    begin
                        scan_next = CW'(scan_reg + 1'b1);
                    end
                    if (nl && me)
                    begin
                        push = 1'b1;
                    end
                    else if (nl || me)
                    begin
                        fifo_we   = 1'b1;
                        tail_next = CW'(tail_reg + 1'b1);
                        if (empty)
                        begin
                            side_next = nl ? SIDE_LOAD : SIDE_EVICT;
                        end
                    end
                    state_next = fin_reg ? F_END : F_IDLE;
                end
            end

            F_HEAD:
            begin
                push      = 1'b1;
                head_next = CW'(head_reg + 1'b1);
                scan_next = CW'(scan_reg + 1'b1);
                if (side_reg == SIDE_LOAD)
                begin
                    push_load = fifo_rd_reg;
                end
                else
                begin
                    push_evict = fifo_rd_reg;
                end
                // Both flags set: the group also joins the tail of the same side
                if (nl && me)
                begin
                    fifo_we   = 1'b1;
                    tail_next = CW'(tail_reg + 1'b1);
                end
                state_next = fin_reg ? F_END : F_IDLE;
            end

            F_END:
            begin
                push               = 1'b1;
                push_cmd.op        = OP_END;
                push_cmd.last      = 1'b1;
                push_cmd.unmatched = !empty;
                scan_next          = '0;
                head_next          = '0;
                tail_next          = '0;
                state_next         = F_IDLE;
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

@@ src/csrp_cmd_queue.sv @@
module csrp_cmd_queue
    import csrp_pkg::*;
#(
    parameter int DATA_W = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csrp_cmd_t         push_cmd,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              head_valid,
    output csrp_cmd_t         head_cmd,
    output logic [DATA_W-1:0] head_data,
    output logic              room
);

    localparam int PW = $clog2(CMDQ_DEPTH);

    csrp_cmd_t         cmd_mem  [CMDQ_DEPTH];
    logic [DATA_W-1:0] data_mem [CMDQ_DEPTH];
    logic [PW-1:0]     rd_ptr_reg, wr_ptr_reg;
    logic [PW:0]       fill_reg;

    assign head_valid = fill_reg != '0;
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_data  = data_mem[rd_ptr_reg];
    // Leave space for the two commands one item may issue
    assign room       = fill_reg <= (PW+1)'(CMDQ_DEPTH - 2);

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                fill_reg <= (PW+1)'(fill_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                fill_reg <= (PW+1)'(fill_reg - 1'b1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/csrp_back.sv @@
module csrp_back
    import csrp_pkg::*;
#(
    parameter int MAX_GROUPS = 1024,
    parameter int GW         = 10,
    parameter int CW         = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CW-1:0]          lim,
    input  logic                   head_valid,
    input  csrp_cmd_t              head_cmd,
    input  logic [GW-1:0]          head_load,
    input  logic [GW-1:0]          head_evict,
    output logic                   pop,
    output logic                   init_done,
    output logic                   strobe,
    output logic                   kind,
    output logic [GROUP_OUT_W-1:0] load_group,
    output logic [SLOT_W-1:0]      target_slot,
    output logic [GROUP_OUT_W-1:0] evicted_group,
    output logic [COUNT_OUT_W-1:0] plan_count,
    output logic                   unmatched,
    output logic                   last
);

    csrp_back_state_t       state_reg, state_next;
    logic [GW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          lim_reg, lim_next;
    logic [COUNT_OUT_W-1:0] total_reg, total_next;
    logic                   init_done_reg, init_done_next;
    logic [GW-1:0]          w_reg, c_reg;
    logic                   last_reg;

    // Group-to-slot map
    csrp_entry_t            map_mem [MAX_GROUPS];
    csrp_entry_t            map_rd_reg;
    csrp_entry_t            map_wdata;
    logic [GW-1:0]          map_waddr;
    logic                   map_we, map_re;

    // Result registers
    logic                   strobe_reg, strobe_next;
    logic                   kind_reg, kind_next;
    logic [GROUP_OUT_W-1:0] load_reg, load_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [GROUP_OUT_W-1:0] evict_reg, evict_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;
    logic                   unm_reg, unm_next;
    logic                   last_out_reg, last_out_next;
    logic                   emit;

    assign init_done     = init_done_reg;
    assign strobe        = strobe_reg;
    assign kind          = kind_reg;
    assign load_group    = load_reg;
    assign target_slot   = slot_reg;
    assign evicted_group = evict_reg;
    assign plan_count    = count_reg;
    assign unmatched     = unm_reg;
    assign last          = last_out_reg;

    // Control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            idx_reg       <= '0;
            lim_reg       <= '0;
            total_reg     <= '0;
            init_done_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            total_reg     <= total_next;
            init_done_reg <= init_done_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Hold the pair under work and the result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg    <= head_load;
            c_reg    <= head_evict;
            last_reg <= head_cmd.last;
        end
        if (emit)
        begin
            kind_reg     <= kind_next;
            load_reg     <= load_next;
            slot_reg     <= slot_next;
            evict_reg    <= evict_next;
            count_reg    <= count_next;
            unm_reg      <= unm_next;
            last_out_reg <= last_out_next;
        end
    end

    // Map memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[head_evict];
        end
    end

    // Sequence commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        total_next     = total_reg;
        init_done_next = init_done_reg;
        pop            = 1'b0;
        map_we         = 1'b0;
        map_re         = 1'b0;
        map_waddr      = idx_reg;
        map_wdata      = '0;
        emit           = 1'b0;
        strobe_next    = 1'b0;
        kind_next      = KIND_COPY;
        load_next      = '0;
        slot_next      = '0;
        evict_next     = '0;
        count_next     = '0;
        unm_next       = 1'b0;
        last_out_next  = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head_cmd.op)
                        OP_PAIR:
                        begin
                            map_re     = 1'b1;
                            state_next = B_CLEAR;
                        end
                        OP_END:
                        begin
                            emit          = 1'b1;
                            strobe_next   = 1'b1;
                            kind_next     = KIND_END;
                            count_next    = total_reg;
                            unm_next      = head_cmd.unmatched;
                            last_out_next = 1'b1;
                            total_next    = '0;
                        end
                        OP_INIT:
                        begin
                            lim_next   = lim;
                            idx_next   = '0;
                            total_next = '0;
                            state_next = B_SWEEP;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end

            B_SWEEP:
            begin
                map_we          = 1'b1;
                map_waddr       = idx_reg;
                map_wdata.valid = CW'(idx_reg) < lim_reg;
                map_wdata.slot  = map_wdata.valid ? SLOT_W'(idx_reg) : '0;
                idx_next        = GW'(idx_reg + 1'b1);
                if (idx_reg == GW'(MAX_GROUPS - 1))
                begin
                    init_done_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end

            B_CLEAR:
            begin
                map_we     = 1'b1;
                map_waddr  = c_reg;
                map_wdata  = '0;
                state_next = B_WRITE;
            end

            B_WRITE:
            begin
                map_we        = 1'b1;
                map_waddr     = w_reg;
                map_wdata     = map_rd_reg;
                emit          = 1'b1;
                strobe_next   = 1'b1;
                kind_next     = KIND_COPY;
                load_next     = GROUP_OUT_W'(w_reg);
                slot_next     = map_rd_reg.valid ? map_rd_reg.slot : '0;
                evict_next    = GROUP_OUT_W'(c_reg);
                last_out_next = last_reg;
                total_next    = COUNT_OUT_W'(total_reg + 1'b1);
                state_next    = B_IDLE;
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

@@ src/cache_slot_reload_planner_top.sv @@
// Cache slot reload planner.
// Items enter on start/action/needs_load/may_evict/final_group; one is taken at
// a rising edge with start high and busy low. action=1 reinitializes the map
// to identity for the first min(cached_groups, group_count) groups; action=0
// presents the flags of the next group. The k-th group to load is paired with
// the k-th group to evict, and each pair yields a copy result; final_group
// adds an end result with the pair count and the unmatched flag.
// Results appear for one cycle with strobe high; the receiver cannot stall,
// and last marks the final result of an item.
// A front sequencer classifies each item (with an extra head-read step when
// it pairs a pending group, and an end step when it ends a pass); a back
// sequencer updates the map (one read, one write port) in read, clear and
// write steps per pair. A four-entry command queue lets the front run ahead,
// so new items are taken while the back still works on earlier pairs, as
// long as the queue has room; a copy result is registered at the write step.
// After reset the back clears the map with busy high; configuration writes on
// cfg_we/cfg_index/cfg_data are taken throughout.
// A reinitialize sweep also rewrites every map entry; later items wait in the
// queue behind it.
module cache_slot_reload_planner_top
    import csrp_pkg::*;
#(
    parameter int MAX_GROUPS = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic                   needs_load,
    input  logic                   may_evict,
    input  logic                   final_group,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   strobe,
    output logic                   kind,
    output logic [GROUP_OUT_W-1:0] load_group,
    output logic [SLOT_W-1:0]      target_slot,
    output logic [GROUP_OUT_W-1:0] evicted_group,
    output logic [COUNT_OUT_W-1:0] plan_count,
    output logic                   unmatched,
    output logic                   last
);

    localparam int GW = $clog2(MAX_GROUPS);
    localparam int CW = (GW + 1 > CFG_W) ? GW + 1 : CFG_W;

    logic [CFG_W-1:0] group_count_reg, cached_groups_reg;
    logic [CW-1:0]    gc_ext, cg_ext, count, lim;
    logic             accept, front_busy, room, init_done;

    logic             push, pop, head_valid;
    csrp_cmd_t        push_cmd, head_cmd;
    logic [GW-1:0]    push_load, push_evict;
    logic [2*GW-1:0]  head_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg   <= CFG_W'(1024);
            cached_groups_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GROUP_COUNT:   group_count_reg   <= cfg_data;
                REG_CACHED_GROUPS: cached_groups_reg <= cfg_data;
                default:           group_count_reg   <= group_count_reg;
            endcase
        end
    end

    // Clamp the group count and the reinitialize limit
    assign gc_ext = CW'(group_count_reg);
    assign cg_ext = CW'(cached_groups_reg);
    assign count  = (gc_ext < CW'(MAX_GROUPS)) ? gc_ext : CW'(MAX_GROUPS);
    assign lim    = (cg_ext < count) ? cg_ext : count;

    assign busy   = front_busy || !room || !init_done;
    assign accept = start && !busy;

    csrp_front #(
        .MAX_GROUPS (MAX_GROUPS),
        .GW         (GW),
        .CW         (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .needs_load  (needs_load),
        .may_evict   (may_evict),
        .final_group (final_group),
        .count       (count),
        .front_busy  (front_busy),
        .push        (push),
        .push_cmd    (push_cmd),
        .push_load   (push_load),
        .push_evict  (push_evict)
    );

    csrp_cmd_queue #(
        .DATA_W (2 * GW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_data  ({push_load, push_evict}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_data  (head_data),
        .room       (room)
    );

    csrp_back #(
        .MAX_GROUPS (MAX_GROUPS),
        .GW         (GW),
        .CW         (CW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .lim           (lim),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_load     (head_data[2*GW-1:GW]),
        .head_evict    (head_data[GW-1:0]),
        .pop           (pop),
        .init_done     (init_done),
        .strobe        (strobe),
        .kind          (kind),
        .load_group    (load_group),
        .target_slot   (target_slot),
        .evicted_group (evicted_group),
        .plan_count    (plan_count),
        .unmatched     (unmatched),
        .last          (last)
    );

endmodule
